/* sv/first_fit_segment_allocator_macros.svh */
// Assertion macros for the first-fit segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ffsa_pkg.sv */
// Shared constants and types of the first-fit segment allocator.
`default_nettype none

package ffsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int POS_BITS     = 16;
  localparam int ID_BITS      = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int TREE_LEAVES  = 1 << IDX_W;
  localparam int TREE_DEPTH   = IDX_W;
  localparam int END_W        = POS_BITS + 1;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_e;

  // One held segment; tag is the slot number it was given.
  typedef struct packed {
    logic                vld;
    logic [ID_BITS-1:0]  owner;
    logic [POS_BITS-1:0] first;
    logic [POS_BITS-1:0] last;
    logic [IDX_W-1:0]    tag;
  } seg_cell_t;

  // Broadcast to the chain: insert or remove at one position.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
  } shift_ctl_t;

  // Candidate travelling up the min tree.
  typedef struct packed {
    logic                vld;
    logic [IDX_W-1:0]    key;
    logic [IDX_W-1:0]    idx;
    logic [POS_BITS-1:0] val;
  } cand_t;

endpackage

`default_nettype wire

/* sv/ffsa_ifs.sv */
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface ffsa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ffsa_pkg::ID_BITS-1:0]  owner_id;
  logic [ffsa_pkg::POS_BITS-1:0] seg_length;

  modport source (output valid, req_type, owner_id, seg_length, input ready);
  modport sink   (input valid, req_type, owner_id, seg_length, output ready);
endinterface

interface ffsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          done_res;
  logic [ffsa_pkg::POS_BITS-1:0] seg_start;
  logic                          table_full;

  modport source (output valid, done_res, seg_start, table_full, input ready);
  modport sink   (input valid, done_res, seg_start, table_full, output ready);
endinterface

interface ffsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffsa_pkg::POS_BITS-1:0] space_length;

  modport source (output valid, space_length, input ready);
  modport sink   (input valid, space_length, output ready);
endinterface

`default_nettype wire

/* sv/first_fit_segment_allocator.sv */
// Top level of the first-fit segment allocator: control, slot map and cell chain.
//
//   channel  dir  payload                                 beat when
//   req_i    in   req_type, owner_id, seg_length          valid & ready
//   rsp_o    out  done_res, seg_start, table_full         valid & ready
//   cfg_i    in   space_length                            valid & ready (always ready)
//
// A request is accepted in S_IDLE, searched in S_SRCH while the registered min tree over
// the cell chain settles, and applied to the chain and slot map in S_APPLY.
// Reset empties the table at once through the cell and slot valid bits; no sweep.
// A result waiting in the output register does not block the next request beat;
// that request only holds in its update cycle until the output register frees.
`default_nettype none

`include "first_fit_segment_allocator_macros.svh"

module first_fit_segment_allocator (
  input  logic               clk_i,
  input  logic               rst_ni,
  ffsa_req_if.sink           req_i,
  ffsa_rsp_if.source         rsp_o,
  ffsa_cfg_if.sink           cfg_i
);
  import ffsa_pkg::*;

  localparam int CNT_W = $clog2(TREE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SRCH  = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  function automatic logic [IDX_W-1:0] first_free(input logic [MAX_SEGMENTS-1:0] used);
    logic [MAX_SEGMENTS-1:0] oh;
    logic [IDX_W-1:0]        res;
    oh  = ~used & (used + MAX_SEGMENTS'(1));
    res = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (oh[k]) begin
        res = res | IDX_W'(k);
      end
    end
    return res;
  endfunction

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [POS_BITS-1:0]     space_q;
  req_kind_e               kind_q;
  logic [ID_BITS-1:0]      id_q;
  logic [POS_BITS-1:0]     len_q;
  logic [MAX_SEGMENTS-1:0] slot_used_q, slot_used_d;

  logic                    rsp_vld_q, rsp_vld_d;
  logic                    rsp_done_q;
  logic [POS_BITS-1:0]     rsp_start_q;
  logic                    rsp_full_q;

  seg_cell_t               cell_w   [MAX_SEGMENTS];
  logic [POS_BITS-1:0]     nstart_w [MAX_SEGMENTS];
  cand_t                   leaf_w   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] fit_w, match_w, vld_vec;
  cand_t                   root_w;

  logic                    go_w, full_w, fit0_w;
  logic [IDX_W-1:0]        free_idx_w;
  shift_ctl_t              ctl_req, ctl_w;
  seg_cell_t               new_cell_w;
  logic                    res_done, res_full, slot_set, slot_clr;
  logic [POS_BITS-1:0]     res_start;
  logic [IDX_W-1:0]        clr_idx;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_cell_t left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_w[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_w[i+1];
    end

    ffsa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (IDX_W'(i)),
      .left_i       (left_w),
      .right_i      (right_w),
      .new_i        (new_cell_w),
      .ctl_i        (ctl_w),
      .id_i         (id_q),
      .len_i        (len_q),
      .space_i      (space_q),
      .cell_o       (cell_w[i]),
      .fit_o        (fit_w[i]),
      .match_o      (match_w[i]),
      .next_start_o (nstart_w[i])
    );

    assign vld_vec[i] = cell_w[i].vld;

    // allocate ranks by chain place (ascending start), release by slot number
    assign leaf_w[i] = '{
      vld: (kind_q == REQ_RELEASE) ? match_w[i] : fit_w[i],
      key: (kind_q == REQ_RELEASE) ? cell_w[i].tag : IDX_W'(i),
      idx: IDX_W'(i),
      val: nstart_w[i]
    };
  end

  ffsa_min_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .leaf_i (leaf_w),
    .root_o (root_w)
  );

  // ---------------- decision ----------------
  assign go_w       = (state_q == S_APPLY) && (!rsp_vld_q || rsp_o.ready);
  assign full_w     = &slot_used_q;
  assign free_idx_w = first_free(slot_used_q);
  assign fit0_w     = (len_q <= space_q) && (!cell_w[0].vld || (len_q <= cell_w[0].first));

  always_comb begin
    res_done  = 1'b0;
    res_start = '0;
    res_full  = 1'b0;
    ctl_req   = '0;
    slot_set  = 1'b0;
    slot_clr  = 1'b0;
    clr_idx   = root_w.key;
    if (kind_q == REQ_RELEASE) begin
      if (root_w.vld) begin
        res_done    = 1'b1;
        ctl_req.rem = 1'b1;
        ctl_req.pos = root_w.idx;
        slot_clr    = 1'b1;
      end
    end else if (len_q != '0) begin
      if (full_w) begin
        res_full = 1'b1;
      end else if (fit0_w) begin
        res_done    = 1'b1;
        ctl_req.ins = 1'b1;
        ctl_req.pos = '0;
        slot_set    = 1'b1;
      end else if (root_w.vld) begin
        res_done    = 1'b1;
        res_start   = root_w.val;
        ctl_req.ins = 1'b1;
        ctl_req.pos = root_w.idx + IDX_W'(1);
        slot_set    = 1'b1;
      end
    end
  end

  assign ctl_w      = go_w ? ctl_req : '0;
  assign new_cell_w = '{
    vld:   1'b1,
    owner: id_q,
    first: res_start,
    last:  res_start + len_q - POS_BITS'(1),
    tag:   free_idx_w
  };

  always_comb begin
    slot_used_d = slot_used_q;
    if (go_w && slot_set) begin
      slot_used_d[free_idx_w] = 1'b1;
    end
    if (go_w && slot_clr) begin
      slot_used_d[clr_idx] = 1'b0;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_SRCH;
          cnt_d   = CNT_W'(TREE_DEPTH - 1);
        end
      end
      S_SRCH: begin
        if (cnt_q == '0) begin
          state_d = S_APPLY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_APPLY: begin
        if (go_w) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (go_w) begin
      rsp_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      space_q     <= '1;
      slot_used_q <= '0;
      rsp_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      slot_used_q <= slot_used_d;
      rsp_vld_q   <= rsp_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        space_q <= cfg_i.space_length;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q <= req_kind_e'(req_i.req_type);
      id_q   <= req_i.owner_id;
      len_q  <= req_i.seg_length;
    end
    if (go_w) begin
      rsp_done_q  <= res_done;
      rsp_start_q <= res_start;
      rsp_full_q  <= res_full;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.done_res   = rsp_done_q;
  assign rsp_o.seg_start  = rsp_start_q;
  assign rsp_o.table_full = rsp_full_q;

  // ---------------- checks ----------------
  `FFSA_ASSERT_IMPL(a_chain_packed, 1'b1, (vld_vec & (vld_vec + MAX_SEGMENTS'(1))) == '0, "cell chain has a hole")
  `FFSA_ASSERT_IMPL(a_count_match, 1'b1, $countones(vld_vec) == $countones(slot_used_q), "chain and slot map disagree")
  `FFSA_ASSERT_NEXT(a_accept_search, req_i.valid && req_i.ready, (state_q == S_SRCH) && !req_i.ready, "no search after request beat")
  `FFSA_ASSERT_IMPL(a_full_refused, rsp_vld_q && rsp_full_q, !rsp_done_q && (rsp_start_q == '0), "full table result also placed")

endmodule

`default_nettype wire

/* sv/ffsa_cell.sv */
// One cell of the sorted segment chain: holds a segment, checks its gap and id.
`default_nettype none

module ffsa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ffsa_pkg::IDX_W-1:0]    idx_i,
  input  ffsa_pkg::seg_cell_t           left_i,
  input  ffsa_pkg::seg_cell_t           right_i,
  input  ffsa_pkg::seg_cell_t           new_i,
  input  ffsa_pkg::shift_ctl_t          ctl_i,
  input  logic [ffsa_pkg::ID_BITS-1:0]  id_i,
  input  logic [ffsa_pkg::POS_BITS-1:0] len_i,
  input  logic [ffsa_pkg::POS_BITS-1:0] space_i,
  output ffsa_pkg::seg_cell_t           cell_o,
  output logic                          fit_o,
  output logic                          match_o,
  output logic [ffsa_pkg::POS_BITS-1:0] next_start_o
);
  import ffsa_pkg::*;

  logic                vld_q;
  logic [ID_BITS-1:0]  owner_q;
  logic [POS_BITS-1:0] first_q;
  logic [POS_BITS-1:0] last_q;
  logic [IDX_W-1:0]    tag_q;
  seg_cell_t           sel_d;
  logic [END_W-1:0]    end_w;

  assign cell_o = '{vld: vld_q, owner: owner_q, first: first_q, last: last_q, tag: tag_q};

  always_comb begin
    sel_d = cell_o;
    if (ctl_i.rem && (idx_i >= ctl_i.pos)) begin
      sel_d = right_i;
    end else if (ctl_i.ins) begin
      if (idx_i == ctl_i.pos) begin
        sel_d = new_i;
      end else if (idx_i > ctl_i.pos) begin
        sel_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= sel_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q <= sel_d.owner;
    first_q <= sel_d.first;
    last_q  <= sel_d.last;
    tag_q   <= sel_d.tag;
  end

  // last position a segment placed just after this one would cover
  assign end_w = {1'b0, last_q} + END_W'(len_i);

  assign fit_o = vld_q && (end_w < {1'b0, space_i}) &&
                 (!right_i.vld || (end_w < {1'b0, right_i.first}));
  assign match_o      = vld_q && (owner_q == id_i);
  assign next_start_o = last_q + POS_BITS'(1);

endmodule

`default_nettype wire

/* sv/ffsa_min_tree.sv */
// Registered binary tree picking the flagged candidate with the lowest key.
`default_nettype none

module ffsa_min_tree (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffsa_pkg::cand_t leaf_i [ffsa_pkg::MAX_SEGMENTS],
  output ffsa_pkg::cand_t root_o
);
  import ffsa_pkg::*;

  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    cand_t r;
    if (a.vld && (!b.vld || (a.key <= b.key))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  cand_t leaf_w [TREE_LEAVES];
  cand_t node_q [1:TREE_LEAVES-1];

  for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
    if (i < MAX_SEGMENTS) begin : g_real
      assign leaf_w[i] = leaf_i[i];
    end else begin : g_pad
      assign leaf_w[i] = '0;
    end
  end

  // heap layout: node k combines 2k and 2k+1, leaves sit past the last node
  for (genvar k = 1; k < TREE_LEAVES; k++) begin : g_node
    if (2 * k >= TREE_LEAVES) begin : g_bottom
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_q[k] <= '0;
        end else begin
          node_q[k] <= cand_min(leaf_w[2*k-TREE_LEAVES], leaf_w[2*k+1-TREE_LEAVES]);
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_q[k] <= '0;
        end else begin
          node_q[k] <= cand_min(node_q[2*k], node_q[2*k+1]);
        end
      end
    end
  end

  assign root_o = node_q[1];

endmodule

`default_nettype wire

/* tb/tb_first_fit_segment_allocator.sv */
// Self-checking testbench for the first-fit segment allocator, with its own table model.
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 16;

  typedef struct packed {
    req_kind_e           kind;
    logic [ID_BITS-1:0]  owner;
    logic [POS_BITS-1:0] len;
  } seg_req_t;

  typedef struct packed {
    logic                done;
    logic [POS_BITS-1:0] start;
    logic                full;
  } seg_rsp_t;

  logic clk_i;
  logic rst_ni;

  ffsa_req_if req_if ();
  ffsa_rsp_if rsp_if ();
  ffsa_cfg_if cfg_if ();

  first_fit_segment_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Table model
  int unsigned space_len;
  bit          held       [MAX_SEGMENTS];
  int unsigned held_owner [MAX_SEGMENTS];
  int unsigned held_first [MAX_SEGMENTS];
  int unsigned held_last  [MAX_SEGMENTS];

  seg_req_t    pending_reqs[$];
  seg_rsp_t    expected_rsps[$];
  int unsigned recent_ids[$];

  int  n_queued;
  int  n_accepted;
  int  mismatches;
  int  cycle_count;
  bit  calm;
  bit  req_taken;
  int  tx_gap;
  bit  tx_noisy;
  int  rx_stall;
  bit  rx_noisy;
  int  hold_left;
  bit  hold_done;

  always #5 clk_i = ~clk_i;

  function automatic bit span_free(int unsigned c, int unsigned len);
    if (c + len > space_len) return 1'b0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (held[k] && held_first[k] <= c + len - 1 && held_last[k] >= c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one request to the model table and returns the answer it should give.
  function automatic seg_rsp_t first_fit_outcome(seg_req_t r);
    seg_rsp_t    o;
    int          free_idx;
    bit          found;
    int unsigned best;
    int unsigned c;
    o = '0;
    if (r.kind == REQ_RELEASE) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        if (!o.done && held[k] && held_owner[k] == r.owner) begin
          held[k] = 1'b0;
          o.done  = 1'b1;
        end
      end
      return o;
    end
    if (r.len == 0) return o;
    free_idx = -1;
    for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
      if (!held[k]) free_idx = k;
    end
    if (free_idx < 0) begin
      o.full = 1'b1;
      return o;
    end
    // candidate starts: 0 and one past each held segment
    found = span_free(0, r.len);
    best  = 0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (held[k]) begin
        c = held_last[k] + 1;
        if ((!found || c < best) && span_free(c, r.len)) begin
          found = 1'b1;
          best  = c;
        end
      end
    end
    if (!found) return o;
    held[free_idx]       = 1'b1;
    held_owner[free_idx] = r.owner;
    held_first[free_idx] = best;
    held_last[free_idx]  = best + r.len - 1;
    o.done  = 1'b1;
    o.start = best[POS_BITS-1:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input seg_rsp_t want, input seg_rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected done=%0b start=%0d full=%0b, got done=%0b start=%0d full=%0b",
               $time, what, want.done, want.start, want.full, got.done, got.start, got.full);
    end
  endtask

  // Request driver
  always @(negedge clk_i) begin : drive_req
    seg_req_t it;
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if ($urandom_range(0, 149) == 0) tx_noisy <= ~tx_noisy;
      if (tx_gap > 0) begin
        req_if.valid <= 1'b0;
        tx_gap       <= tx_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        it = pending_reqs.pop_front();
        req_if.valid      <= 1'b1;
        req_if.req_type   <= it.kind;
        req_if.owner_id   <= it.owner;
        req_if.seg_length <= it.len;
        if (!calm && tx_noisy && hold_left == 0 && $urandom_range(0, 5) == 0)
          tx_gap <= $urandom_range(1, 12);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready with stall bursts; the long hold-off overrides
  always @(negedge clk_i) begin
    if ($urandom_range(0, 149) == 0) rx_noisy <= ~rx_noisy;
    if (rx_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!calm && rx_noisy && $urandom_range(0, 5) == 0) rx_stall <= $urandom_range(1, 12);
    end
  end

  // One long receiver hold-off mid-run so the block backs up onto its input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 400 && pending_reqs.size() > 40) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // Monitor: predict on request beats, check on response beats
  always @(posedge clk_i) begin : monitor
    seg_req_t r;
    seg_rsp_t got;
    seg_rsp_t want;
    req_taken <= req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{done: rsp_if.done_res, start: rsp_if.seg_start, full: rsp_if.table_full};
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", '0, got);
        end else begin
          want = expected_rsps.pop_front();
          if (got.done !== want.done)   report_mismatch("done_res mismatch", want, got);
          if (got.start !== want.start) report_mismatch("seg_start mismatch", want, got);
          if (got.full !== want.full)   report_mismatch("table_full mismatch", want, got);
        end
      end
      if (req_if.valid && req_if.ready) begin
        r = '{kind: req_kind_e'(req_if.req_type), owner: req_if.owner_id,
              len: req_if.seg_length};
        want = first_fit_outcome(r);
        expected_rsps = {expected_rsps, want};
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_req(input req_kind_e kind, input int unsigned owner,
                           input int unsigned len);
    seg_req_t r;
    r = '{kind: kind, owner: owner[ID_BITS-1:0], len: len[POS_BITS-1:0]};
    pending_reqs = {pending_reqs, r};
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_space_len(input int unsigned v);
    @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.space_length <= v[POS_BITS-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    space_len = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed churn: allocations of sizes scaled to the space and
  // releases of ids handed out earlier, with bias swinging between fill and drain.
  task automatic queue_random_phase(input int unsigned span, input int count);
    int          scale;
    int          alloc_pct;
    int          pick;
    int unsigned id;
    int unsigned len;
    scale     = (span / 40 > 1) ? span / 40 : 1;
    alloc_pct = 85;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) alloc_pct = ($urandom_range(0, 1) == 0) ? 85 : 35;
      if ($urandom_range(0, 99) < alloc_pct) begin
        id = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 31) : $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 3)       len = 0;
        else if (pick < 8)  len = $urandom_range(0, 65535);
        else if (pick < 14) len = $urandom_range(1, span);
        else                len = $urandom_range(1, scale);
        queue_req(REQ_ALLOC, id, len);
        recent_ids = {recent_ids, id};
        if (recent_ids.size() > 80) void'(recent_ids.pop_front());
      end else begin
        if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, recent_ids.size() - 1);
          id   = recent_ids[pick];
          recent_ids.delete(pick);
        end else begin
          id = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 65535);
        end
        queue_req(REQ_RELEASE, id, $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned spans[8];
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_ALLOC;
    req_if.owner_id     = '0;
    req_if.seg_length   = '0;
    rsp_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.space_length = '0;
    space_len           = 65535;
    tx_noisy            = 1'b1;
    rx_noisy            = 1'b1;
    foreach (held[k]) begin
      held[k]       = 1'b0;
      held_owner[k] = 0;
      held_first[k] = 0;
      held_last[k]  = 0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, space at its reset length
    queue_req(REQ_ALLOC,   16'h0000, 0);        // zero length refused
    queue_req(REQ_ALLOC,   16'hFFFF, 16'hFFFF); // whole space
    queue_req(REQ_ALLOC,   16'h0001, 1);        // no room left
    queue_req(REQ_RELEASE, 16'h1234, 16'hFFFF); // unknown id
    queue_req(REQ_RELEASE, 16'hFFFF, 0);
    queue_req(REQ_ALLOC,   7, 100);
    queue_req(REQ_ALLOC,   7, 50);              // duplicate id
    queue_req(REQ_ALLOC,   8, 10);
    queue_req(REQ_RELEASE, 7, 0);               // lowest slot of the pair goes
    queue_req(REQ_ALLOC,   9, 60);              // reuses the hole at 0
    queue_req(REQ_ALLOC,   10, 40);             // gap after a held segment
    queue_req(REQ_RELEASE, 7, 0);
    queue_req(REQ_ALLOC,   11, 16'h8000);
    queue_req(REQ_ALLOC,   16'hAAAA, 16'h5555);
    queue_req(REQ_RELEASE, 16'h5555, 16'hAAAA);
    wait_idle();

    // shrink below held segments
    write_space_len(1);
    queue_req(REQ_ALLOC,   3, 1);
    queue_req(REQ_RELEASE, 9, 0);
    queue_req(REQ_ALLOC,   3, 1);
    queue_req(REQ_ALLOC,   4, 1);
    queue_req(REQ_ALLOC,   4, 2);
    queue_req(REQ_RELEASE, 10, 0);
    queue_req(REQ_RELEASE, 8, 0);
    queue_req(REQ_RELEASE, 11, 0);
    queue_req(REQ_RELEASE, 3, 0);
    queue_req(REQ_RELEASE, 16'hAAAA, 0);
    wait_idle();

    spans = '{300, 65535, 4000, 1, 1000, 50, 0, 65535};
    spans[6] = $urandom_range(1, 65535);
    for (int p = 0; p < 8; p++) begin
      write_space_len(spans[p]);
      if (p == 7) calm = 1'b1;
      queue_random_phase(spans[p], 150);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ffsa_pkg.sv
sv/ffsa_ifs.sv
sv/ffsa_cell.sv
sv/ffsa_min_tree.sv
sv/first_fit_segment_allocator.sv
tb/tb_first_fit_segment_allocator.sv
